/* hw/rtl/swsc_pkg.sv */
// Shared types and constants for the sliding-window speckle contrast block.
package swsc_pkg;

    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int ROWS_W    = 13;
    localparam int FRAC_BITS = 12;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;

    localparam logic [1:0] REG_ROW_LENGTH = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT  = 2'd1;
    localparam logic [1:0] REG_X_RADIUS   = 2'd2;
    localparam logic [1:0] REG_Y_RADIUS   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_DRAIN,
        ST_MUL1,
        ST_CHK,
        ST_MUL2,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage

/* hw/rtl/sliding_window_speckle_contrast.sv */
// Top level of the sliding-window speckle contrast block.
//
// Pixels enter on the in channel (in_valid, in_ready, intensity) in raster
// order. Every pixel that completes a window lying fully inside the image
// yields one word on the out channel (out_valid, out_ready, contrast,
// invalid, last_of_image); other pixels yield nothing.
// Each pixel is written into a line store memory. For a producing pixel the
// window is then read back from that memory one entry per cycle in the sum
// phase. The contrast then needs multiplies and a compare, a restoring
// divider of one quotient bit per cycle over the full 80 bit dividend, and a
// 16 step square root; a pixel without a result does not enter the work
// unit. The divider width is the bulk of the latency. One pixel is in work
// at a time; a new pixel is accepted while the previous result still waits
// in the output register. When the receiver stalls, the finished result
// waits in the work unit and no pixel is taken. Reset sets the registers to
// their defaults and both positions to zero. Any configuration write
// restarts the image.
module sliding_window_speckle_contrast #(
    parameter int MAX_ROW_LENGTH = 1024,
    parameter int MAX_X_RADIUS   = 7,
    parameter int MAX_Y_RADIUS   = 7,
    parameter int PIXEL_BITS     = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swsc_pkg::ADDR_W-1:0]       paddr,
    input  logic [swsc_pkg::DATA_W-1:0]       pwdata,
    output logic [swsc_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [swsc_pkg::IN_W-1:0]         intensity,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [swsc_pkg::OUT_W-1:0]        contrast,
    output logic                              invalid,
    output logic                              last_of_image
);

    localparam int CW   = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
    localparam int LW   = CW + 1;
    localparam int RING = 2 * MAX_Y_RADIUS + 1;
    localparam int SLW  = $clog2(RING);
    localparam int XRW  = $clog2(MAX_X_RADIUS + 1);
    localparam int YRW  = $clog2(MAX_Y_RADIUS + 1);
    localparam int WXW  = $clog2(2 * MAX_X_RADIUS + 2);
    localparam int WYW  = $clog2(2 * MAX_Y_RADIUS + 2);
    localparam int NMAX = (2 * MAX_X_RADIUS + 1) * (2 * MAX_Y_RADIUS + 1);
    localparam int NB   = $clog2(NMAX + 1);
    localparam int PW   = (PIXEL_BITS < swsc_pkg::IN_W) ? PIXEL_BITS : swsc_pkg::IN_W;
    localparam int SB   = PW + NB;
    localparam int QB   = 2 * PW + NB;
    localparam int DW   = (2 * SB > QB + NB) ? 2 * SB : QB + NB;
    localparam int BB   = DW + NB;
    localparam int RB   = DW + NB + 2 * swsc_pkg::FRAC_BITS;
    localparam int DCW  = $clog2(RB + 1);
    localparam int RW   = swsc_pkg::ROWS_W;
    localparam int KW   = swsc_pkg::OUT_W;
    localparam int VW   = 2 * KW;
    localparam int KBW  = $clog2(KW);
    localparam int MEMD = RING << CW;

    // Configuration registers.
    logic [10:0] row_length_reg;
    logic [12:0] row_count_reg;
    logic [2:0]  x_radius_reg;
    logic [2:0]  y_radius_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= 11'd1024;
            row_count_reg  <= 13'd1024;
            x_radius_reg   <= 3'd1;
            y_radius_reg   <= 3'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                swsc_pkg::REG_ROW_LENGTH: row_length_reg <= pwdata[10:0];
                swsc_pkg::REG_ROW_COUNT:  row_count_reg  <= pwdata[12:0];
                swsc_pkg::REG_X_RADIUS:   x_radius_reg   <= pwdata[2:0];
                swsc_pkg::REG_Y_RADIUS:   y_radius_reg   <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            swsc_pkg::REG_ROW_LENGTH: prdata = {21'd0, row_length_reg};
            swsc_pkg::REG_ROW_COUNT:  prdata = {19'd0, row_count_reg};
            swsc_pkg::REG_X_RADIUS:   prdata = {29'd0, x_radius_reg};
            swsc_pkg::REG_Y_RADIUS:   prdata = {29'd0, y_radius_reg};
            default:                  prdata = '0;
        endcase
    end

    // Effective geometry after clamping.
    logic [LW-1:0]  len_eff;
    logic [RW-1:0]  rows_eff;
    logic [XRW-1:0] xr_eff;
    logic [YRW-1:0] yr_eff;
    logic [WXW-1:0] wx;
    logic [WYW-1:0] wy;
    logic [NB-1:0]  n_pix;

    always_comb
    begin
        if (row_length_reg == 11'd0)
            len_eff = LW'(1);
        else if (32'(row_length_reg) > MAX_ROW_LENGTH)
            len_eff = LW'(MAX_ROW_LENGTH);
        else
            len_eff = LW'(row_length_reg);
        rows_eff = (row_count_reg == 13'd0) ? RW'(1) : row_count_reg;
        xr_eff = (32'(x_radius_reg) > MAX_X_RADIUS) ? XRW'(MAX_X_RADIUS) : XRW'(x_radius_reg);
        yr_eff = (32'(y_radius_reg) > MAX_Y_RADIUS) ? YRW'(MAX_Y_RADIUS) : YRW'(y_radius_reg);
        wx = WXW'({xr_eff, 1'b1});
        wy = WYW'({yr_eff, 1'b1});
        n_pix = NB'(32'(wx) * 32'(wy));
    end

    // Raster position.
    logic [CW-1:0]  col_reg;
    logic [RW-1:0]  row_reg;
    logic [SLW-1:0] slot_reg;
    logic           in_acc;
    logic           produce;
    logic           col_end;
    logic           row_end;

    assign in_acc  = in_valid && in_ready;
    assign col_end = (LW'(col_reg) + LW'(1)) >= len_eff;
    assign row_end = (row_reg + RW'(1)) >= rows_eff;
    assign produce = (LW'(col_reg) >= LW'({xr_eff, 1'b0}))
                  && (row_reg >= RW'({yr_eff, 1'b0}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (cfg_wr)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (in_acc)
        begin
            if (col_end)
            begin
                col_reg <= '0;
                if (row_end)
                begin
                    row_reg  <= '0;
                    slot_reg <= '0;
                end
                else
                begin
                    row_reg  <= row_reg + RW'(1);
                    slot_reg <= (32'(slot_reg) == RING - 1) ? '0 : slot_reg + SLW'(1);
                end
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // Line store memory, one write and one read port.
    logic [PW-1:0]      line_mem [MEMD];
    logic [PW-1:0]      rdata_reg;
    logic [SLW+CW-1:0]  rd_addr;
    logic [SLW-1:0]     rd_slot_reg;
    logic [CW-1:0]      rd_col_reg;

    assign rd_addr = {rd_slot_reg, rd_col_reg};

    always_ff @(posedge clk)
    begin
        if (in_acc)
            line_mem[{slot_reg, col_reg}] <= intensity[PW-1:0];
        rdata_reg <= line_mem[rd_addr];
    end

    // Work unit.
    swsc_pkg::state_t state_reg, state_next;

    logic [CW-1:0]  start_col_reg;
    logic [WXW-1:0] xi_reg;
    logic [WYW-1:0] yj_reg;
    logic           pend_reg;
    logic           last_reg;
    logic [SB-1:0]  s_reg;
    logic [QB-1:0]  q_reg;
    logic [DW-1:0]  ss_reg;
    logic [DW-1:0]  nq_reg;
    logic [DW-1:0]  d_reg;
    logic [BB-1:0]  base_reg;
    logic [RB-1:0]  rhs_reg;
    logic [BB-1:0]  rem_reg;
    logic [VW-1:0]  quo_reg;
    logic           sat_reg;
    logic [DCW-1:0] cnt_reg;
    logic [KW-1:0]  k_reg;
    logic [KBW-1:0] kb_reg;
    logic [KW-1:0]  res_k_reg;
    logic           res_inv_reg;

    logic           sum_last;
    logic [BB:0]    trial;
    logic           trial_ge;
    logic [VW-1:0]  sq_val;
    logic [KW-1:0]  k_try;
    logic [VW-1:0]  k_sq;
    logic           can_load;
    logic [SLW:0]   start_slot_raw;

    assign sum_last = (xi_reg == wx - WXW'(1)) && (yj_reg == wy - WYW'(1));
    assign trial    = {rem_reg, rhs_reg[RB-1]};
    assign trial_ge = trial >= {1'b0, base_reg};
    assign sq_val   = sat_reg ? '1 : quo_reg;
    assign k_try    = k_reg | (KW'(1) << kb_reg);
    assign k_sq     = VW'(k_try) * VW'(k_try);
    assign can_load = !out_valid || out_ready;
    assign in_ready = (state_reg == swsc_pkg::ST_IDLE);
    assign start_slot_raw = {1'b0, slot_reg} - (SLW+1)'({yr_eff, 1'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= swsc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swsc_pkg::ST_IDLE:
                if (in_acc && produce)
                    state_next = swsc_pkg::ST_SUM;
            swsc_pkg::ST_SUM:
                if (sum_last)
                    state_next = swsc_pkg::ST_DRAIN;
            swsc_pkg::ST_DRAIN:
                state_next = swsc_pkg::ST_MUL1;
            swsc_pkg::ST_MUL1:
                if (s_reg == '0 || n_pix == NB'(1))
                    state_next = swsc_pkg::ST_DONE;
                else
                    state_next = swsc_pkg::ST_CHK;
            swsc_pkg::ST_CHK:
                if (nq_reg <= ss_reg)
                    state_next = swsc_pkg::ST_DONE;
                else
                    state_next = swsc_pkg::ST_MUL2;
            swsc_pkg::ST_MUL2:
                state_next = swsc_pkg::ST_DIV;
            swsc_pkg::ST_DIV:
                if (cnt_reg == DCW'(1))
                    state_next = swsc_pkg::ST_SQRT;
            swsc_pkg::ST_SQRT:
                if (kb_reg == '0)
                    state_next = swsc_pkg::ST_DONE;
            swsc_pkg::ST_DONE:
                if (can_load)
                    state_next = swsc_pkg::ST_IDLE;
            default:
                state_next = swsc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            s_reg <= s_reg + SB'(rdata_reg);
            q_reg <= q_reg + QB'((2*PW)'(rdata_reg) * (2*PW)'(rdata_reg));
        end
        unique case (state_reg)
            swsc_pkg::ST_IDLE:
            begin
                pend_reg <= 1'b0;
                if (in_acc)
                begin
                    last_reg      <= col_end && row_end;
                    start_col_reg <= col_reg - CW'({xr_eff, 1'b0});
                    rd_col_reg    <= col_reg - CW'({xr_eff, 1'b0});
                    rd_slot_reg   <= start_slot_raw[SLW] ?
                                     SLW'(start_slot_raw + (SLW+1)'(RING)) :
                                     start_slot_raw[SLW-1:0];
                    xi_reg        <= '0;
                    yj_reg        <= '0;
                    s_reg         <= '0;
                    q_reg         <= '0;
                end
            end
            swsc_pkg::ST_SUM:
            begin
                pend_reg <= 1'b1;
                if (xi_reg == wx - WXW'(1))
                begin
                    xi_reg      <= '0;
                    yj_reg      <= yj_reg + WYW'(1);
                    rd_col_reg  <= start_col_reg;
                    rd_slot_reg <= (32'(rd_slot_reg) == RING - 1) ? '0 :
                                   rd_slot_reg + SLW'(1);
                end
                else
                begin
                    xi_reg     <= xi_reg + WXW'(1);
                    rd_col_reg <= rd_col_reg + CW'(1);
                end
            end
            swsc_pkg::ST_DRAIN:
                pend_reg <= 1'b0;
            swsc_pkg::ST_MUL1:
            begin
                ss_reg      <= DW'(s_reg) * DW'(s_reg);
                nq_reg      <= DW'(q_reg) * DW'(n_pix);
                res_k_reg   <= '0;
                res_inv_reg <= (s_reg == '0) || (n_pix == NB'(1));
            end
            swsc_pkg::ST_CHK:
                d_reg <= nq_reg - ss_reg;
            swsc_pkg::ST_MUL2:
            begin
                base_reg <= BB'(ss_reg) * BB'(n_pix - NB'(1));
                rhs_reg  <= (RB'(d_reg) * RB'(n_pix)) << (2 * swsc_pkg::FRAC_BITS);
                rem_reg  <= '0;
                quo_reg  <= '0;
                sat_reg  <= 1'b0;
                cnt_reg  <= DCW'(RB);
            end
            swsc_pkg::ST_DIV:
            begin
                rhs_reg <= rhs_reg << 1;
                rem_reg <= trial_ge ? BB'(trial - {1'b0, base_reg}) : BB'(trial);
                quo_reg <= {quo_reg[VW-2:0], trial_ge};
                sat_reg <= sat_reg | quo_reg[VW-1];
                cnt_reg <= cnt_reg - DCW'(1);
                k_reg   <= '0;
                kb_reg  <= KBW'(KW - 1);
            end
            swsc_pkg::ST_SQRT:
            begin
                if (k_sq <= sq_val)
                begin
                    k_reg     <= k_try;
                    res_k_reg <= k_try;
                end
                else
                begin
                    res_k_reg <= k_reg;
                end
                kb_reg <= kb_reg - KBW'(1);
            end
            swsc_pkg::ST_DONE: ;
            default: ;
        endcase
    end

    // Output register.
    logic out_valid_reg;
    logic [KW-1:0] contrast_reg;
    logic invalid_reg;
    logic last_out_reg;
    logic load_out;

    assign load_out = (state_reg == swsc_pkg::ST_DONE) && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            contrast_reg <= res_k_reg;
            invalid_reg  <= res_inv_reg;
            last_out_reg <= last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign contrast      = contrast_reg;
    assign invalid       = invalid_reg;
    assign last_of_image = last_out_reg;

endmodule
